// ===== hw/rtl/ils_pkg.sv =====
// ils_pkg: command and status codes and the result record of the indexed list store.
// Standalone; used by ils_ctrl and indexed_list_store.
package ils_pkg;

	localparam logic [2:0] CMD_READ   = 3'd0;
	localparam logic [2:0] CMD_FRONT  = 3'd1;
	localparam logic [2:0] CMD_APPEND = 3'd2;
	localparam logic [2:0] CMD_INSERT = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [31:0] RV_MISS = 32'hFFFF_FFFF;
	localparam logic [31:0] RV_NONE = 32'h0000_0000;

	typedef struct packed {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic [5:0]  list_length;
	} res_t;

endpackage

// ===== hw/rtl/indexed_list_store.sv =====
// indexed_list_store: ordered list of signed 32-bit values with indexed read, insert, remove.
// Depends on ils_pkg, ils_mem, ils_ctrl.
//
// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------
// command  | cmd_valid / cmd_ready  | command, position, value
// result   | res_valid / res_ready  | read_value, status, list_length
//
// A read passes an issue and a wait state; an insert shifts the n - p entries at
// and above p up a slot, one entry per cycle, then writes the value; a remove
// shifts the n - p - 1 above p down; n is the length before the command and p
// the position; others and refusals go straight to done. No clearing pass after reset.
// One command is in flight at a time; a held result stalls the sequencer at its end.
module indexed_list_store #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic [2:0]         command,
	input  logic signed [15:0] position,
	input  logic signed [31:0] value,
	output logic               res_valid,
	input  logic               res_ready,
	output logic signed [31:0] read_value,
	output logic [1:0]         status,
	output logic [5:0]         list_length
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic          done;
	logic          slot_free;
	ils_pkg::res_t res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;
	logic          res_valid_q;
	ils_pkg::res_t res_q;

	assign slot_free = !res_valid_q || res_ready;

	ils_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.command(command),
		.position(position),
		.value(value),
		.done(done),
		.take(slot_free),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ils_mem #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register: hold the transaction until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (slot_free) begin
			res_valid_q <= done;
			if (done) begin
				res_q <= res;
			end
		end
	end

	assign res_valid   = res_valid_q;
	assign read_value  = res_q.read_value;
	assign status      = res_q.status;
	assign list_length = res_q.list_length;

endmodule

// ===== hw/rtl/ils_mem.sv =====
// ils_mem: entry storage, one write port and one read port with registered read data.
// No dependencies.
module ils_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/ils_ctrl.sv =====
// ils_ctrl: command decode and shift sequencer; moves one entry per cycle through ils_mem.
// Depends on ils_pkg.
module ils_ctrl #(
	parameter int CAPACITY = 32,
	parameter int AW       = 5,
	parameter int CW       = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  logic [2:0]     command,
	input  logic [15:0]    position,
	input  logic [31:0]    value,
	output logic           done,
	input  logic           take,
	output ils_pkg::res_t  res,
	output logic           mem_we,
	output logic [AW-1:0]  mem_waddr,
	output logic [31:0]    mem_wdata,
	output logic           mem_re,
	output logic [AW-1:0]  mem_raddr,
	input  logic [31:0]    mem_rdata
);

	localparam int XW = (CW > 15) ? CW : 15;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_ISSUE,
		S_RD_WAIT,
		S_SHIFT,
		S_PUT,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] moves_q;
	logic [AW-1:0] src_q;
	logic [AW-1:0] dst_q;
	logic [AW-1:0] put_q;
	logic [31:0]   val_q;
	logic          up_q;
	logic          pend_q;
	ils_pkg::res_t res_q;

	logic          pos_neg;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic          pos_lt;
	logic          pos_gt;
	logic          full;
	logic [XW-1:0] ins_x;
	logic [AW-1:0] src_step;

	assign pos_neg = position[15];
	assign pos_x   = XW'(position[14:0]);
	assign cnt_x   = XW'(count_q);
	assign pos_lt  = !pos_neg && (pos_x < cnt_x);
	assign pos_gt  = !pos_neg && (pos_x > cnt_x);
	assign full    = (count_q == CW'(CAPACITY));

	// insert slot for front, append and positional insert
	always_comb begin
		case (command)
			ils_pkg::CMD_FRONT:  ins_x = '0;
			ils_pkg::CMD_APPEND: ins_x = cnt_x;
			default:             ins_x = pos_neg ? '0 : pos_x;
		endcase
	end

	// shared index stepper: walk down for inserts, up for removes
	assign src_step = up_q ? (src_q - AW'(1)) : (src_q + AW'(1));

	assign cmd_ready = (state_q == S_IDLE);
	assign done      = (state_q == S_DONE);
	assign res       = res_q;

	assign mem_re    = (state_q == S_RD_ISSUE) || ((state_q == S_SHIFT) && (moves_q != '0));
	assign mem_raddr = src_q;
	assign mem_we    = ((state_q == S_SHIFT) && pend_q) || (state_q == S_PUT);
	assign mem_waddr = (state_q == S_PUT) ? put_q : dst_q;
	assign mem_wdata = (state_q == S_PUT) ? val_q : mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
			moves_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pend_q <= 1'b0;
					if (cmd_valid) begin
						res_q.read_value <= ils_pkg::RV_NONE;
						res_q.status     <= ils_pkg::ST_DONE;
						res_q.list_length <= 6'(count_q);
						val_q            <= value;
						state_q          <= S_DONE;
						case (command)
							ils_pkg::CMD_READ: begin
								if (pos_lt) begin
									src_q   <= AW'(pos_x);
									state_q <= S_RD_ISSUE;
								end else begin
									res_q.read_value <= ils_pkg::RV_MISS;
									res_q.status     <= ils_pkg::ST_RANGE;
								end
							end
							ils_pkg::CMD_FRONT, ils_pkg::CMD_APPEND,
							ils_pkg::CMD_INSERT: begin
								if ((command == ils_pkg::CMD_INSERT) && pos_gt) begin
									res_q.status <= ils_pkg::ST_RANGE;
								end else if (full) begin
									res_q.status <= ils_pkg::ST_FULL;
								end else begin
									up_q    <= 1'b1;
									put_q   <= AW'(ins_x);
									src_q   <= AW'(count_q - CW'(1));
									moves_q <= count_q - CW'(ins_x);
									count_q <= count_q + CW'(1);
									res_q.list_length <= 6'(count_q + CW'(1));
									state_q <= S_SHIFT;
								end
							end
							ils_pkg::CMD_REMOVE: begin
								if (pos_lt) begin
									up_q    <= 1'b0;
									src_q   <= AW'(pos_x + XW'(1));
									moves_q <= count_q - CW'(1) - CW'(pos_x);
									count_q <= count_q - CW'(1);
									res_q.list_length <= 6'(count_q - CW'(1));
									state_q <= S_SHIFT;
								end else begin
									res_q.status <= ils_pkg::ST_RANGE;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_ISSUE: begin
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					res_q.read_value <= mem_rdata;
					state_q          <= S_DONE;
				end
				S_SHIFT: begin
					// read one entry ahead, write it in the next cycle one slot over
					if (moves_q != '0) begin
						pend_q  <= 1'b1;
						dst_q   <= up_q ? (src_q + AW'(1)) : (src_q - AW'(1));
						src_q   <= src_step;
						moves_q <= moves_q - CW'(1);
					end else begin
						pend_q  <= 1'b0;
						state_q <= up_q ? S_PUT : S_DONE;
					end
				end
				S_PUT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> (count_q <= CW'(CAPACITY)))
		else $error("entry count above capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q))
		else $error("entry count changed mid-command");

	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (mem_waddr <= AW'(CAPACITY - 1)))
		else $error("write beyond capacity");

	a_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_PUT) || (state_q == S_DONE)) |-> !pend_q)
		else $error("shift write still pending at finish");

endmodule
